/* src/bll_pkg.sv */
// shared constants, codes and types for the line rasterizer
package bll_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 14;

    // configuration register width and frame address width
    localparam int REG_BITS   = 14;
    localparam int ADDR_BITS  = 26;
    localparam int COLOR_BITS = 32;

    // configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [REG_BITS-1:0] FRAME_WIDTH_RST  = 14'd800;
    localparam logic [REG_BITS-1:0] FRAME_HEIGHT_RST = 14'd600;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // per-pixel flags carried from the stepper to the address stage
    typedef struct packed {
        logic pixel_valid;
        logic last_pixel;
    } t_pix_ctl;

endpackage

/* src/bll_cmd_if.sv */
// command channel: start/next commands with line endpoints and color
interface bll_cmd_if #(
    parameter int COORD_BITS = bll_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic signed [COORD_BITS-1:0]    start_x;
    logic signed [COORD_BITS-1:0]    start_y;
    logic signed [COORD_BITS-1:0]    end_x;
    logic signed [COORD_BITS-1:0]    end_y;
    logic [bll_pkg::COLOR_BITS-1:0]  pixel_color;

    modport source (
        output valid, command, start_x, start_y, end_x, end_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, command, start_x, start_y, end_x, end_y, pixel_color,
        output ready
    );
endinterface

/* src/bll_pix_if.sv */
// pixel channel: one result item per command
interface bll_pix_if #(
    parameter int COORD_BITS = bll_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            pixel_valid;
    logic signed [COORD_BITS-1:0]    pixel_x;
    logic signed [COORD_BITS-1:0]    pixel_y;
    logic [bll_pkg::ADDR_BITS-1:0]   pixel_address;
    logic [bll_pkg::COLOR_BITS-1:0]  color_out;
    logic                            last_pixel;
    logic                            off_frame;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, pixel_address, color_out,
               last_pixel, off_frame,
        input  ready
    );
    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, pixel_address, color_out,
               last_pixel, off_frame,
        output ready
    );
endinterface

/* src/bll_cfg_regs.sv */
// frame size configuration registers
module bll_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bll_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bll_pkg::REG_BITS-1:0]      i_cfg_wdata,
    output logic [bll_pkg::REG_BITS-1:0]      o_frame_width,
    output logic [bll_pkg::REG_BITS-1:0]      o_frame_height
);

    logic [bll_pkg::REG_BITS-1:0] r_frame_width;
    logic [bll_pkg::REG_BITS-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bll_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bll_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bll_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                bll_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;

endmodule

/* src/bll_stepper.sv */
// line setup and per-pixel error-term stepping, one pixel register
module bll_stepper #(
    parameter int COORD_BITS = bll_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic signed [COORD_BITS-1:0]      i_start_x,
    input  logic signed [COORD_BITS-1:0]      i_start_y,
    input  logic signed [COORD_BITS-1:0]      i_end_x,
    input  logic signed [COORD_BITS-1:0]      i_end_y,
    input  logic [bll_pkg::COLOR_BITS-1:0]    i_pixel_color,
    output logic                              o_dn_valid,
    input  logic                              i_dn_ready,
    output logic signed [COORD_BITS-1:0]      o_px,
    output logic signed [COORD_BITS-1:0]      o_py,
    output logic [bll_pkg::COLOR_BITS-1:0]    o_color,
    output bll_pkg::t_pix_ctl                 o_ctl
);

    localparam int EW = COORD_BITS + 3;
    localparam int DW = COORD_BITS + 1;
    localparam logic [COORD_BITS-1:0] STEP_POS = COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] STEP_NEG = '1;

    // line state
    logic                           r_active;
    logic [COORD_BITS-1:0]          r_x, r_y;
    logic [EW-1:0]                  r_err;
    logic [COORD_BITS-1:0]          r_steps;
    logic [COORD_BITS-1:0]          r_adx, r_ady;
    logic                           r_xneg, r_yneg, r_xmaj;
    logic [bll_pkg::COLOR_BITS-1:0] r_lcolor;

    logic                           n_active;
    logic [COORD_BITS-1:0]          n_x, n_y;
    logic [EW-1:0]                  n_err;
    logic [COORD_BITS-1:0]          n_steps;
    logic [COORD_BITS-1:0]          n_adx, n_ady;
    logic                           n_xneg, n_yneg, n_xmaj;
    logic [bll_pkg::COLOR_BITS-1:0] n_lcolor;

    // pixel register
    logic                           r_vld, n_vld;
    logic [COORD_BITS-1:0]          r_px, r_py, n_px, n_py;
    logic [bll_pkg::COLOR_BITS-1:0] r_color, n_color;
    bll_pkg::t_pix_ctl              r_ctl, n_ctl;

    logic accept;

    // setup arithmetic
    logic [DW-1:0]         dx, dy;
    logic [COORD_BITS-1:0] adx, ady, dmaj, dmin;
    logic                  xmaj;
    logic [EW-1:0]         err0;

    // stepping arithmetic
    logic                  err_ge0;
    logic [COORD_BITS-1:0] smaj, smin;
    logic [EW-1:0]         err_adv;
    logic [COORD_BITS-1:0] x_adv, y_adv;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_vld || i_dn_ready;

    assign dx   = DW'(i_end_x) - DW'(i_start_x);
    assign dy   = DW'(i_end_y) - DW'(i_start_y);
    assign adx  = dx[DW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady  = dy[DW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign xmaj = (adx >= ady);
    assign dmaj = xmaj ? adx : ady;
    assign dmin = xmaj ? ady : adx;
    assign err0 = EW'({dmin, 1'b0}) - EW'(dmaj);

    // one bresenham step from the last emitted pixel
    assign err_ge0 = !r_err[EW-1];
    assign smaj    = r_xmaj ? r_adx : r_ady;
    assign smin    = r_xmaj ? r_ady : r_adx;
    assign err_adv = r_err + EW'({smin, 1'b0}) - (err_ge0 ? EW'({smaj, 1'b0}) : '0);
    assign x_adv   = (r_xmaj || err_ge0) ? r_x + (r_xneg ? STEP_NEG : STEP_POS) : r_x;
    assign y_adv   = (!r_xmaj || err_ge0) ? r_y + (r_yneg ? STEP_NEG : STEP_POS) : r_y;

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_err    = r_err;
        n_steps  = r_steps;
        n_adx    = r_adx;
        n_ady    = r_ady;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_xmaj   = r_xmaj;
        n_lcolor = r_lcolor;
        n_px     = r_px;
        n_py     = r_py;
        n_color  = r_color;
        n_ctl    = r_ctl;
        n_vld    = r_vld && !i_dn_ready;

        if (accept) begin
            n_vld = 1'b1;
            if (i_command == bll_pkg::CMD_START) begin
                n_adx    = adx;
                n_ady    = ady;
                n_xneg   = !(dx != '0 && !dx[DW-1]);
                n_yneg   = !(dy != '0 && !dy[DW-1]);
                n_xmaj   = xmaj;
                n_err    = err0;
                n_steps  = dmaj;
                n_active = (dmaj != '0);
                n_x      = i_start_x;
                n_y      = i_start_y;
                n_lcolor = i_pixel_color;
                n_px     = i_start_x;
                n_py     = i_start_y;
                n_color  = i_pixel_color;
                n_ctl    = '{pixel_valid: 1'b1, last_pixel: (dmaj == '0)};
            end else if (r_active) begin
                n_x      = x_adv;
                n_y      = y_adv;
                n_err    = err_adv;
                n_steps  = r_steps - STEP_POS;
                n_active = (r_steps != STEP_POS);
                n_px     = x_adv;
                n_py     = y_adv;
                n_color  = r_lcolor;
                n_ctl    = '{pixel_valid: 1'b1, last_pixel: (r_steps == STEP_POS)};
            end else begin
                // next with no line: an all-zero item
                n_px    = '0;
                n_py    = '0;
                n_color = '0;
                n_ctl   = '{pixel_valid: 1'b0, last_pixel: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_vld    <= n_vld;
        end
        r_x      <= n_x;
        r_y      <= n_y;
        r_err    <= n_err;
        r_steps  <= n_steps;
        r_adx    <= n_adx;
        r_ady    <= n_ady;
        r_xneg   <= n_xneg;
        r_yneg   <= n_yneg;
        r_xmaj   <= n_xmaj;
        r_lcolor <= n_lcolor;
        r_px     <= n_px;
        r_py     <= n_py;
        r_color  <= n_color;
        r_ctl    <= n_ctl;
    end

    assign o_dn_valid = r_vld;
    assign o_px       = r_px;
    assign o_py       = r_py;
    assign o_color    = r_color;
    assign o_ctl      = r_ctl;

    // an active line always has pixels left
    a_active_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_steps != '0)
        else $error("active line with no steps left");

    // a start always produces a real pixel
    a_start_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_command == bll_pkg::CMD_START |=> r_vld && r_ctl.pixel_valid)
        else $error("start did not produce a pixel");

    // next with no line gives an empty item
    a_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_command == bll_pkg::CMD_NEXT && !r_active
        |=> r_vld && !r_ctl.pixel_valid)
        else $error("pixel emitted while idle");

    // major axis is the larger delta (x on a tie)
    a_major_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_xmaj ? r_adx >= r_ady : r_ady > r_adx))
        else $error("major axis inconsistent with deltas");

endmodule

/* src/bll_addr_unit.sv */
// frame bounds check and address multiply, output register
module bll_addr_unit #(
    parameter int COORD_BITS = bll_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_up_valid,
    output logic                              o_up_ready,
    input  logic signed [COORD_BITS-1:0]      i_px,
    input  logic signed [COORD_BITS-1:0]      i_py,
    input  logic [bll_pkg::COLOR_BITS-1:0]    i_color,
    input  bll_pkg::t_pix_ctl                 i_ctl,
    input  logic [bll_pkg::REG_BITS-1:0]      i_frame_width,
    input  logic [bll_pkg::REG_BITS-1:0]      i_frame_height,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_pixel_valid,
    output logic signed [COORD_BITS-1:0]      o_pixel_x,
    output logic signed [COORD_BITS-1:0]      o_pixel_y,
    output logic [bll_pkg::ADDR_BITS-1:0]     o_pixel_address,
    output logic [bll_pkg::COLOR_BITS-1:0]    o_color_out,
    output logic                              o_last_pixel,
    output logic                              o_off_frame
);

    localparam int CW     = (COORD_BITS > bll_pkg::REG_BITS) ? COORD_BITS : bll_pkg::REG_BITS;
    localparam int PROD_W = COORD_BITS + bll_pkg::REG_BITS;
    localparam int SW     = (PROD_W + 1 > bll_pkg::ADDR_BITS) ? PROD_W + 1 : bll_pkg::ADDR_BITS;

    logic                            r_vld, n_vld;
    logic                            r_pvalid;
    logic [COORD_BITS-1:0]           r_x, r_y;
    logic [bll_pkg::ADDR_BITS-1:0]   r_addr, n_addr;
    logic [bll_pkg::COLOR_BITS-1:0]  r_color;
    logic                            r_last;
    logic                            r_off, n_off;

    logic            load;
    logic            out_of_frame;
    logic [PROD_W-1:0] prod;
    logic [SW-1:0]   sum;

    assign o_up_ready = !r_vld || i_ready;
    assign load       = i_up_valid && o_up_ready;

    // negative coordinates fail on the sign bit, so unsigned compares suffice
    assign out_of_frame = i_px[COORD_BITS-1] || i_py[COORD_BITS-1]
                       || (CW'(unsigned'(i_px)) >= CW'(i_frame_width))
                       || (CW'(unsigned'(i_py)) >= CW'(i_frame_height));

    assign prod = PROD_W'(unsigned'(i_py)) * PROD_W'(i_frame_width);
    assign sum  = SW'(prod) + SW'(unsigned'(i_px));

    assign n_off  = i_ctl.pixel_valid && out_of_frame;
    assign n_addr = (i_ctl.pixel_valid && !out_of_frame) ? sum[bll_pkg::ADDR_BITS-1:0] : '0;
    assign n_vld  = load ? 1'b1 : (r_vld && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (load) begin
            r_pvalid <= i_ctl.pixel_valid;
            r_x      <= i_px;
            r_y      <= i_py;
            r_addr   <= n_addr;
            r_color  <= i_color;
            r_last   <= i_ctl.last_pixel;
            r_off    <= n_off;
        end
    end

    assign o_valid         = r_vld;
    assign o_pixel_valid   = r_pvalid;
    assign o_pixel_x       = r_x;
    assign o_pixel_y       = r_y;
    assign o_pixel_address = r_addr;
    assign o_color_out     = r_color;
    assign o_last_pixel    = r_last;
    assign o_off_frame     = r_off;

    // an off-frame pixel never carries a write address
    a_off_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_off |-> r_addr == '0 && r_pvalid)
        else $error("off-frame pixel with nonzero address");

endmodule

/* src/bresenham_line_rasterizer.sv */
// top level of the bresenham line pixel generator
//
// usage:
//   i_cmd  command channel (valid/ready). command 0 starts a line from
//          (start_x, start_y) to (end_x, end_y) in pixel_color and returns
//          the first pixel; command 1 returns the next pixel of the line.
//   o_pix  one result item per command item, in order. last_pixel marks the
//          final pixel; a next command with no line active returns an item
//          with every field zero (pixel_valid 0). off_frame pixels carry
//          address 0 and must not be written.
//   cfg    i_cfg_we / i_cfg_index / i_cfg_wdata write frame_width (index 0)
//          and frame_height (index 1); change them only while idle.
// timing:
//   a result leaves through the stepper register, which loads at the accept,
//   and then through the y*width address register, which drives o_pix.
//   throughput is one item per cycle while o_pix is not stalled, set by the
//   single error-term add and compare of a bresenham step.
// reset (synchronous, active low) clears the line and both pipeline stages,
// and loads frame size 800 x 600. a stalled o_pix holds its item; the stall
// backs up through both stages, which keep taking items while a slot is free.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = bll_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bll_cmd_if.sink                           i_cmd,
    bll_pix_if.source                         o_pix,
    input  logic                              i_cfg_we,
    input  logic [bll_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bll_pkg::REG_BITS-1:0]      i_cfg_wdata
);

    // frame size registers
    logic [bll_pkg::REG_BITS-1:0] frame_width;
    logic [bll_pkg::REG_BITS-1:0] frame_height;

    // stepper to address stage
    logic                            stp_valid;
    logic                            stp_ready;
    logic signed [COORD_BITS-1:0]    stp_x;
    logic signed [COORD_BITS-1:0]    stp_y;
    logic [bll_pkg::COLOR_BITS-1:0]  stp_color;
    bll_pkg::t_pix_ctl               stp_ctl;

    bll_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_frame_width  (frame_width),
        .o_frame_height (frame_height)
    );

    // setup on start, one error-term step per next
    bll_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_cmd.valid),
        .o_in_ready    (i_cmd.ready),
        .i_command     (i_cmd.command),
        .i_start_x     (i_cmd.start_x),
        .i_start_y     (i_cmd.start_y),
        .i_end_x       (i_cmd.end_x),
        .i_end_y       (i_cmd.end_y),
        .i_pixel_color (i_cmd.pixel_color),
        .o_dn_valid    (stp_valid),
        .i_dn_ready    (stp_ready),
        .o_px          (stp_x),
        .o_py          (stp_y),
        .o_color       (stp_color),
        .o_ctl         (stp_ctl)
    );

    // bounds check and x + y*width, registered onto the output channel
    bll_addr_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_up_valid      (stp_valid),
        .o_up_ready      (stp_ready),
        .i_px            (stp_x),
        .i_py            (stp_y),
        .i_color         (stp_color),
        .i_ctl           (stp_ctl),
        .i_frame_width   (frame_width),
        .i_frame_height  (frame_height),
        .o_valid         (o_pix.valid),
        .i_ready         (o_pix.ready),
        .o_pixel_valid   (o_pix.pixel_valid),
        .o_pixel_x       (o_pix.pixel_x),
        .o_pixel_y       (o_pix.pixel_y),
        .o_pixel_address (o_pix.pixel_address),
        .o_color_out     (o_pix.color_out),
        .o_last_pixel    (o_pix.last_pixel),
        .o_off_frame     (o_pix.off_frame)
    );

endmodule
